/* sv/itrd_pkg.sv */
package itrd_pkg;

	localparam int VALUE_BITS = 32;
	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 8;
	localparam int CNT_W      = $clog2(VALUE_BITS);
	localparam int IDX_W      = $clog2(VALUE_BITS);
	localparam int ND_W       = $clog2(VALUE_BITS + 1);

	localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd35;
	localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
	localparam logic [RADIX_W-1:0] DECIMAL_LIMIT = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic ready;
		logic load;
		logic div_step;
		logic push;
		logic emit_sign;
		logic emit_digit;
	} itrd_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic div_done;
		logic quot_zero;
		logic negative;
		logic slot_free;
		logic last_digit;
	} itrd_sts_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DECIMAL_LIMIT) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_ALPHA + CHAR_W'(d - DECIMAL_LIMIT);
		end
		return c;
	endfunction

endpackage

/* sv/itrd_if.sv */
interface itrd_num_if import itrd_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface itrd_char_if import itrd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

interface itrd_cfg_if import itrd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [RADIX_W-1:0] radix;

	modport source (output valid, output radix, input ready);
	modport sink (input valid, input radix, output ready);
endinterface

/* sv/integer_to_radix_digits.sv */
// Each digit takes one pass of the bit-serial divider (32 steps) and a push onto the stack;
// then the sign, if negative, and the digits go out, most significant first. A new number
// is taken only in idle, once the last digit of the previous one is in the output register.
// Output register lets the final character wait while the next number is accepted.
// Reset: arst_n asynchronous, active low; radix returns to 35, controller to idle.
module integer_to_radix_digits import itrd_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	itrd_num_if.sink    number,
	itrd_char_if.source text,
	itrd_cfg_if.sink    cfg
);

	// controller/datapath handshake
	itrd_cmd_t cmd;
	itrd_sts_t sts;

	// sequencer: accept, divide per digit, push, then stream sign and digits out
	itrd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// radix register, magnitude/remainder divider, digit stack, output register
	itrd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number),
		.text   (text),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

/* sv/itrd_ctrl.sv */
module itrd_ctrl import itrd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  itrd_sts_t sts,
	output itrd_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_PUSH = 5'b00100,
		S_SIGN = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (sts.in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				if (!sts.quot_zero) begin
					state_d = S_DIV;
				end else if (sts.negative) begin
					state_d = S_SIGN;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_SIGN: begin
				if (sts.slot_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.slot_free) begin
					cmd.emit_digit = 1'b1;
					if (sts.last_digit) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* sv/itrd_dp.sv */
module itrd_dp import itrd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	itrd_num_if.sink  number,
	itrd_char_if.source text,
	itrd_cfg_if.sink  cfg,
	input  itrd_cmd_t cmd,
	output itrd_sts_t sts
);

	logic [RADIX_W-1:0]    radix_q;
	logic [RADIX_W-1:0]    base;
	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag_q;
	logic [RADIX_W-1:0]    rem_q;
	logic [RADIX_W:0]      trial;
	logic                  fits;
	logic [CNT_W-1:0]      bit_cnt_q;
	logic [ND_W-1:0]       nd_q;
	logic [ND_W-1:0]       nd_dec;
	logic [IDX_W-1:0]      rd_idx;
	logic                  neg_q;
	logic [RADIX_W-1:0]    digits_q [VALUE_BITS];
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     character_q;
	logic                  last_q;
	logic                  emit;

	// radix register, always ready; the divider reads it on every step,
	// so it is to be changed only between numbers; the block does not enforce that
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg.valid) begin
			radix_q <= cfg.radix;
		end
	end

	always_comb begin
		if (radix_q < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = radix_q;
		end
	end

	assign number.ready = cmd.ready;
	assign raw          = number.value;

	// restoring division step: one quotient bit per cycle
	assign trial = {rem_q, mag_q[VALUE_BITS-1]};
	assign fits  = trial >= {1'b0, base};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= raw[VALUE_BITS-1];
			mag_q <= raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], fits};
			rem_q <= fits ? RADIX_W'(trial - {1'b0, base}) : trial[RADIX_W-1:0];
		end else if (cmd.push) begin
			rem_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			nd_q      <= '0;
		end else if (cmd.load) begin
			bit_cnt_q <= '0;
			nd_q      <= '0;
		end else if (cmd.div_step) begin
			bit_cnt_q <= bit_cnt_q + 1'b1;
		end else if (cmd.push) begin
			bit_cnt_q <= '0;
			nd_q      <= nd_q + 1'b1;
		end else if (cmd.emit_digit) begin
			nd_q <= nd_dec;
		end
	end

	// digit stack, least significant pushed first
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			digits_q[nd_q[IDX_W-1:0]] <= rem_q;
		end
	end

	assign nd_dec = nd_q - 1'b1;
	assign rd_idx = nd_dec[IDX_W-1:0];

	// output register
	assign emit = cmd.emit_sign || cmd.emit_digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (text.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			character_q <= CHAR_MINUS;
			last_q      <= 1'b0;
		end else if (cmd.emit_digit) begin
			character_q <= digit_char(digits_q[rd_idx]);
			last_q      <= nd_q == ND_W'(1);
		end
	end

	assign text.valid     = out_valid_q;
	assign text.character = character_q;
	assign text.last      = last_q;

	assign sts.in_valid   = number.valid;
	assign sts.div_done   = bit_cnt_q == CNT_W'(VALUE_BITS - 1);
	assign sts.quot_zero  = mag_q == '0;
	assign sts.negative   = neg_q;
	assign sts.slot_free  = !out_valid_q || text.ready;
	assign sts.last_digit = nd_q == ND_W'(1);

endmodule

/* sv/itrd_checker.sv */
module itrd_checker import itrd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              num_valid,
	input logic              num_ready,
	input logic              txt_valid,
	input logic              txt_ready,
	input logic [CHAR_W-1:0] txt_character,
	input logic              txt_last
);

	// stalled character holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && !txt_ready |=> txt_valid && $stable(txt_character) && $stable(txt_last))
		else $error("character changed under stall");

	// busy once a number is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		num_valid && num_ready |=> !num_ready)
		else $error("ready after input transfer");

	// sign never ends a number
	a_minus: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && txt_character == CHAR_MINUS |-> !txt_last)
		else $error("minus flagged last");

	// idle only with no unfinished number pending
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		num_ready |-> !(txt_valid && !txt_last))
		else $error("ready mid-number");

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.num_valid     (number.valid),
	.num_ready     (number.ready),
	.txt_valid     (text.valid),
	.txt_ready     (text.ready),
	.txt_character (text.character),
	.txt_last      (text.last)
);
